### sv/stp_pkg.sv
// stp_pkg: shared types, codes and helper functions for the span timestamp profiler.
// No dependencies; used by the interfaces, the top level and stp_engine.
package stp_pkg;

    localparam int KIND_W   = 2;
    localparam int STAMP_W  = 64;
    localparam int IDX_W    = 4;
    localparam int TIME_W   = 40;
    localparam int VB_W     = 7;
    localparam int PERIOD_W = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 24;
    localparam int MUL_A_W  = 20;
    localparam int MUL_B_W  = 24;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 64;

    localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

    localparam logic RES_TOTAL = 1'b0;
    localparam logic RES_SPAN  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STAMP_BITS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 1'd1;

    localparam logic [VB_W-1:0]     VB_RESET     = 7'd64;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd65536;

    localparam logic [TIME_W-1:0]  MAX40    = 40'hFF_FFFF_FFFF;
    localparam logic [MUL_B_W-1:0] W_OLD    = 24'd60293;
    localparam logic [MUL_B_W-1:0] W_NEW    = 24'd5243;
    localparam logic [ACC_W-1:0]   HALF_Q16 = 64'd32768;

    typedef struct packed {
        logic [VB_W-1:0]     stamp_valid_bits;
        logic [PERIOD_W-1:0] tick_period_q16;
    } t_cfg;

    typedef struct packed {
        logic              result_kind;
        logic [TIME_W-1:0] time_ns;
        logic              time_valid;
    } t_result;

    function automatic logic [STAMP_W-1:0] wrap_mask(input logic [VB_W-1:0] vb);
        logic [STAMP_W-1:0] m;
        if (vb == '0 || vb[VB_W-1]) begin
            m = '1;
        end else begin
            m = ~({STAMP_W{1'b1}} << vb[VB_W-2:0]);
        end
        return m;
    endfunction

    function automatic logic [TIME_W-1:0] sat40(input logic [STAMP_W:0] v);
        logic [TIME_W-1:0] r;
        if (|v[STAMP_W:TIME_W]) begin
            r = MAX40;
        end else begin
            r = v[TIME_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/stp_if.sv
// stp_if: valid/ready channel interfaces for items, results and register writes.
// Depends on stp_pkg for field widths.
interface stp_item_if;
    logic                          valid;
    logic                          ready;
    logic [stp_pkg::KIND_W-1:0]    kind;
    logic [stp_pkg::STAMP_W-1:0]   stamp_value;
    logic [stp_pkg::IDX_W-1:0]     span_index;

    modport source (output valid, kind, stamp_value, span_index, input ready);
    modport sink   (input valid, kind, stamp_value, span_index, output ready);
endinterface

interface stp_result_if;
    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic [stp_pkg::TIME_W-1:0]   time_ns;
    logic                         time_valid;

    modport source (output valid, result_kind, time_ns, time_valid, input ready);
    modport sink   (input valid, result_kind, time_ns, time_valid, output ready);
endinterface

interface stp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [stp_pkg::CFG_IDX_W-1:0]   index;
    logic [stp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/span_timestamp_profiler_unit.sv
// Span timestamp profiler, top level. Begin items stamp the frame start, marks add
// wrap-masked stamp differences into per-span tick sums held in a small RAM, an end
// item converts each sum to ns and folds it into a per-span EMA (0.92/0.08, Q16) kept
// in a second RAM, and emits the saturated total; a query returns one smoothed span.
// Begin and ignored items leave the sequencer idle, a mark reads and writes back its
// span's tick sum, a query reads the RAMs unless its span is out of range, and an end
// walks every span, its run set by the per-span read-modify-write and the single 20x24
// multiplier doing two partial products per span for the conversion and four more for
// the EMA once the span is seeded. Results leave through an output register, so the
// next item is taken while a result waits. Register writes are taken every cycle.
// Depends on stp_pkg, stp_if, stp_engine, stp_ram.
module span_timestamp_profiler_unit #(
    parameter int SPANS            = 6,
    parameter int STAMPS_PER_FRAME = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stp_cfg_if.sink       i_cfg,
    stp_item_if.sink      i_item,
    stp_result_if.source  o_result
);

    stp_pkg::t_cfg    r_cfg;
    logic             r_out_valid;
    stp_pkg::t_result r_out;
    logic             res_valid;
    stp_pkg::t_result res;
    logic             res_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stamp_valid_bits <= stp_pkg::VB_RESET;
            r_cfg.tick_period_q16  <= stp_pkg::PERIOD_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                stp_pkg::CFG_STAMP_BITS:
                    r_cfg.stamp_valid_bits <= i_cfg.data[stp_pkg::VB_W-1:0];
                stp_pkg::CFG_TICK_PERIOD:
                    r_cfg.tick_period_q16 <= i_cfg.data[stp_pkg::PERIOD_W-1:0];
            endcase
        end
    end

    stp_engine #(
        .SPANS            (SPANS),
        .STAMPS_PER_FRAME (STAMPS_PER_FRAME)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // output register
    assign res_ready = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.result_kind = r_out.result_kind;
    assign o_result.time_ns     = r_out.time_ns;
    assign o_result.time_valid  = r_out.time_valid;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && r_out_valid && !o_result.ready) |=> $stable(r_out))
        else $error("output register overwritten while stalled");

    a_no_item_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |-> !res_valid)
        else $error("item taken while a result is pending");

    a_total_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.result_kind == stp_pkg::RES_TOTAL)
            |-> o_result.time_valid)
        else $error("frame total reported as invalid");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.ready && !res_valid) |=> !o_result.valid)
        else $error("result repeated after transfer");
`endif

endmodule

### sv/stp_ram.sv
// stp_ram: simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module stp_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 6,
    parameter int AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### sv/stp_engine.sv
// stp_engine: item sequencer over the span tick and smoothed-time memories,
// with one shared 20x24 multiplier and accumulator. Depends on stp_pkg, stp_if, stp_ram.
module stp_engine #(
    parameter int SPANS            = 6,
    parameter int STAMPS_PER_FRAME = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stp_item_if.sink         i_item,
    input  stp_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output stp_pkg::t_result o_res,
    input  logic             i_res_ready
);

    localparam int AW = (SPANS > 1) ? $clog2(SPANS) : 1;
    localparam int CW = $clog2(STAMPS_PER_FRAME + 1);
    localparam int TW = stp_pkg::TIME_W;
    localparam int AH = stp_pkg::MUL_A_W;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_M_RD = 5'd1;
    localparam logic [4:0] S_M_WR = 5'd2;
    localparam logic [4:0] S_Q_RD = 5'd3;
    localparam logic [4:0] S_Q_OUT = 5'd4;
    localparam logic [4:0] S_E_RD = 5'd5;
    localparam logic [4:0] S_E_LD = 5'd6;
    localparam logic [4:0] S_E_M0 = 5'd7;
    localparam logic [4:0] S_E_M1 = 5'd8;
    localparam logic [4:0] S_E_M2 = 5'd9;
    localparam logic [4:0] S_E_NS = 5'd10;
    localparam logic [4:0] S_E_W0 = 5'd11;
    localparam logic [4:0] S_E_W1 = 5'd12;
    localparam logic [4:0] S_E_W2 = 5'd13;
    localparam logic [4:0] S_E_W3 = 5'd14;
    localparam logic [4:0] S_E_W4 = 5'd15;
    localparam logic [4:0] S_E_EV = 5'd16;
    localparam logic [4:0] S_E_WR = 5'd17;
    localparam logic [4:0] S_EMIT = 5'd18;

    logic [4:0]                  r_state, n_state;
    logic                        r_open;
    logic [CW-1:0]               r_count;
    logic [SPANS-1:0]            r_tvalid;
    logic [SPANS-1:0]            r_seeded;
    logic                        r_pv;

    logic [stp_pkg::STAMP_W-1:0] r_prev;
    logic [stp_pkg::STAMP_W-1:0] r_diff;
    logic [stp_pkg::IDX_W-1:0]   r_idx;
    logic [AW-1:0]               r_span;
    logic [TW-1:0]               r_ticks;
    logic [TW-1:0]               r_old;
    logic                        r_seed;
    logic [TW-1:0]               r_ns;
    logic [TW-1:0]               r_new;
    logic [TW-1:0]               r_total;
    logic [stp_pkg::PROD_W-1:0]  r_prod;
    logic                        r_psh;
    logic [stp_pkg::ACC_W-1:0]   r_acc;
    stp_pkg::t_result            r_res;

    logic                        accept;
    logic                        idx_ok;
    logic [AW-1:0]               idx_a;
    logic [AW-1:0]               rd_addr;
    logic                        rd_en;
    logic [TW-1:0]               ticks_rdata;
    logic [TW-1:0]               ema_rdata;
    logic                        ticks_we;
    logic [TW-1:0]               ticks_cur;
    logic [TW-1:0]               ticks_sum;
    logic                        ema_we;
    logic [AH-1:0]               mul_a;
    logic [stp_pkg::MUL_B_W-1:0] mul_b;
    logic                        mul_go;
    logic                        mul_sh;
    logic [stp_pkg::ACC_W-1:0]   prod_ext;
    logic [TW-1:0]               acc_sat;
    logic [TW-1:0]               total_sum;
    logic                        last_span;

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign o_res_valid  = (r_state == S_EMIT);
    assign o_res        = r_res;

    assign idx_ok    = ({1'b0, r_idx} < (stp_pkg::IDX_W + 1)'(SPANS));
    assign idx_a     = r_idx[AW-1:0];
    assign last_span = (r_span == AW'(SPANS - 1));

    assign rd_addr = (r_state == S_M_RD || r_state == S_Q_RD) ? idx_a : r_span;
    assign rd_en   = (r_state == S_M_RD || r_state == S_Q_RD || r_state == S_E_RD);

    assign ticks_we  = (r_state == S_M_WR);
    assign ticks_cur = r_tvalid[idx_a] ? ticks_rdata : '0;
    assign ticks_sum = stp_pkg::sat40({1'b0, r_diff} + {25'd0, ticks_cur});
    assign ema_we    = (r_state == S_E_WR);

    assign acc_sat   = stp_pkg::sat40({17'd0, r_acc[stp_pkg::ACC_W-1:16]});
    assign total_sum = stp_pkg::sat40({25'd0, r_total} + {25'd0, r_new});
    assign prod_ext  = r_psh ? {r_prod, {AH{1'b0}}} : {{AH{1'b0}}, r_prod};

    stp_ram #(.WIDTH(TW), .DEPTH(SPANS), .AW(AW)) u_ticks_ram (
        .i_clk   (i_clk),
        .i_we    (ticks_we),
        .i_waddr (idx_a),
        .i_wdata (ticks_sum),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ticks_rdata)
    );

    stp_ram #(.WIDTH(TW), .DEPTH(SPANS), .AW(AW)) u_ema_ram (
        .i_clk   (i_clk),
        .i_we    (ema_we),
        .i_waddr (r_span),
        .i_wdata (r_new),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ema_rdata)
    );

    // multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_go = 1'b0;
        mul_sh = 1'b0;
        unique case (r_state)
            S_E_M0: begin
                mul_a = r_ticks[AH-1:0];  mul_b = i_cfg.tick_period_q16;
                mul_go = 1'b1;
            end
            S_E_M1: begin
                mul_a = r_ticks[TW-1:AH]; mul_b = i_cfg.tick_period_q16;
                mul_go = 1'b1; mul_sh = 1'b1;
            end
            S_E_W0: begin
                mul_a = r_old[AH-1:0];    mul_b = stp_pkg::W_OLD;
                mul_go = 1'b1;
            end
            S_E_W1: begin
                mul_a = r_old[TW-1:AH];   mul_b = stp_pkg::W_OLD;
                mul_go = 1'b1; mul_sh = 1'b1;
            end
            S_E_W2: begin
                mul_a = r_ns[AH-1:0];     mul_b = stp_pkg::W_NEW;
                mul_go = 1'b1;
            end
            S_E_W3: begin
                mul_a = r_ns[TW-1:AH];    mul_b = stp_pkg::W_NEW;
                mul_go = 1'b1; mul_sh = 1'b1;
            end
            default: begin
                mul_go = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.kind)
                        stp_pkg::KIND_BEGIN: n_state = S_IDLE;
                        stp_pkg::KIND_MARK: begin
                            if (r_open && r_count < CW'(STAMPS_PER_FRAME)
                                && ({1'b0, i_item.span_index}
                                    < (stp_pkg::IDX_W + 1)'(SPANS))) begin
                                n_state = S_M_RD;
                            end
                        end
                        stp_pkg::KIND_END: begin
                            if (r_open) begin
                                n_state = S_E_RD;
                            end
                        end
                        stp_pkg::KIND_QUERY: begin
                            if ({1'b0, i_item.span_index} < (stp_pkg::IDX_W + 1)'(SPANS)) begin
                                n_state = S_Q_RD;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                    endcase
                end
            end
            S_M_RD:  n_state = S_M_WR;
            S_M_WR:  n_state = S_IDLE;
            S_Q_RD:  n_state = S_Q_OUT;
            S_Q_OUT: n_state = S_EMIT;
            S_E_RD:  n_state = S_E_LD;
            S_E_LD:  n_state = S_E_M0;
            S_E_M0:  n_state = S_E_M1;
            S_E_M1:  n_state = S_E_M2;
            S_E_M2:  n_state = S_E_NS;
            S_E_NS:  n_state = r_seed ? S_E_W0 : S_E_WR;
            S_E_W0:  n_state = S_E_W1;
            S_E_W1:  n_state = S_E_W2;
            S_E_W2:  n_state = S_E_W3;
            S_E_W3:  n_state = S_E_W4;
            S_E_W4:  n_state = S_E_EV;
            S_E_EV:  n_state = S_E_WR;
            S_E_WR:  n_state = last_span ? S_EMIT : S_E_RD;
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_open   <= 1'b0;
            r_count  <= '0;
            r_tvalid <= '0;
            r_seeded <= '0;
            r_pv     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= mul_go;
            if (accept) begin
                unique case (i_item.kind)
                    stp_pkg::KIND_BEGIN: begin
                        r_open   <= 1'b1;
                        r_count  <= CW'(1);
                        r_tvalid <= '0;
                    end
                    stp_pkg::KIND_MARK: begin
                        if (r_open && r_count < CW'(STAMPS_PER_FRAME)) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    stp_pkg::KIND_END: begin
                        r_open <= 1'b0;
                    end
                    stp_pkg::KIND_QUERY: begin
                        r_open <= r_open;
                    end
                endcase
            end
            if (ticks_we) begin
                r_tvalid[idx_a] <= 1'b1;
            end
            if (ema_we) begin
                r_seeded[r_span] <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_psh  <= mul_sh;
        if (r_state == S_E_LD || r_state == S_E_NS) begin
            r_acc <= stp_pkg::HALF_Q16;
        end else if (r_pv) begin
            r_acc <= r_acc + prod_ext;
        end
        if (accept) begin
            r_idx <= i_item.span_index;
            if (i_item.kind == stp_pkg::KIND_BEGIN) begin
                r_prev <= i_item.stamp_value;
            end
            if (i_item.kind == stp_pkg::KIND_MARK && r_open
                && r_count < CW'(STAMPS_PER_FRAME)) begin
                r_diff <= (i_item.stamp_value - r_prev)
                          & stp_pkg::wrap_mask(i_cfg.stamp_valid_bits);
                r_prev <= i_item.stamp_value;
            end
            if (i_item.kind == stp_pkg::KIND_END) begin
                r_span  <= '0;
                r_total <= '0;
            end
            if (i_item.kind == stp_pkg::KIND_QUERY) begin
                r_res <= '{result_kind: stp_pkg::RES_SPAN, time_ns: '0, time_valid: 1'b0};
            end
        end
        if (r_state == S_Q_OUT && idx_ok) begin
            r_res <= '{result_kind: stp_pkg::RES_SPAN,
                       time_ns: r_seeded[idx_a] ? ema_rdata : '0,
                       time_valid: r_seeded[idx_a]};
        end
        if (r_state == S_E_LD) begin
            r_ticks <= r_tvalid[r_span] ? ticks_rdata : '0;
            r_old   <= ema_rdata;
            r_seed  <= r_seeded[r_span];
        end
        if (r_state == S_E_NS) begin
            r_ns  <= acc_sat;
            r_new <= acc_sat;
        end
        if (r_state == S_E_EV) begin
            r_new <= acc_sat;
        end
        if (r_state == S_E_WR) begin
            r_total <= total_sum;
            r_span  <= r_span + AW'(1);
            if (last_span) begin
                r_res <= '{result_kind: stp_pkg::RES_TOTAL, time_ns: total_sum,
                           time_valid: 1'b1};
            end
        end
    end

endmodule
